// ===== sv/des_pkg.sv =====
// Package for the DES block cipher: permutation tables, S-boxes and round helpers.
// Used by the round stage, the top level and the checker; depends on nothing.
package des_pkg;

	localparam int ROUNDS_DEF = 16;

	typedef logic [6:0] perm_idx_t;

	localparam perm_idx_t [0:63] IP_TAB = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
		64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	localparam perm_idx_t [0:63] FP_TAB = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
		37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	localparam perm_idx_t [0:47] E_TAB = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
	localparam perm_idx_t [0:31] P_TAB = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	localparam perm_idx_t [0:55] PC1_TAB = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
		60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
		61,53,45,37,29,21,13,5,28,20,12,4};
	localparam perm_idx_t [0:47] PC2_TAB = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
	localparam logic [1:0] ROT_TAB [0:15] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	localparam logic [3:0] SBOX [0:7][0:63] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,5,6,11,3}};

	function automatic logic [63:0] ip_perm(input logic [63:0] v);
		logic [63:0] o;
		for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(IP_TAB[i])];
		return o;
	endfunction

	function automatic logic [63:0] fp_perm(input logic [63:0] v);
		logic [63:0] o;
		for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(FP_TAB[i])];
		return o;
	endfunction

	function automatic logic [55:0] pc1_perm(input logic [63:0] v);
		logic [55:0] o;
		for (int i = 0; i < 56; i++) o[55-i] = v[64-int'(PC1_TAB[i])];
		return o;
	endfunction

	function automatic logic [47:0] pc2_perm(input logic [55:0] v);
		logic [47:0] o;
		for (int i = 0; i < 48; i++) o[47-i] = v[56-int'(PC2_TAB[i])];
		return o;
	endfunction

	function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
		return (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
		logic [47:0] e;
		logic [31:0] s;
		logic [31:0] o;
		logic [5:0] six;
		for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(E_TAB[i])];
		e = e ^ k;
		for (int b = 0; b < 8; b++) begin
			six = e[47-6*b -: 6];
			s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) o[31-i] = s[32-int'(P_TAB[i])];
		return o;
	endfunction

endpackage

// ===== sv/des_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
// Depends on nothing; used by the top level for both channels.
interface des_stream_if #(parameter int W = 64);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/des_round.sv =====
// One pipelined DES round: a Feistel step and its stage register.
// Depends on des_pkg.
module des_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [63:0] lr_in,
	input  logic [47:0] key,
	output logic        vld_out,
	output logic [63:0] lr_out
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lr_out <= {lr_in[31:0], lr_in[63:32] ^ des_pkg::feistel(lr_in[31:0], key)};
		end
	end
endmodule

// ===== sv/des_block_cipher.sv =====
// DES ECB block cipher top level: key schedule, input stage, sixteen round stages, output.
// Depends on des_pkg, des_stream_if and des_round.
// One 64-bit block is accepted per cycle while the output is not stalled; its result passes
// through an input stage holding the initial permutation, one register stage per round, and an
// output register after the final permutation. The whole pipe advances together, so a stall at
// the output holds every stage. A key write recomputes all sixteen subkeys in the same cycle.
module des_block_cipher #(
	parameter int ROUNDS = des_pkg::ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	des_stream_if.sink   in_ch,
	des_stream_if.source out_ch
);
	logic [63:0] key_q;
	logic [47:0] sk_q [ROUNDS];
	logic [47:0] sk_n [ROUNDS];
	logic        en;
	logic        vld [ROUNDS+1];
	logic [63:0] lr [ROUNDS+1];
	logic        cmd [ROUNDS+1];
	logic        out_vld_q;
	logic [63:0] out_q;

	always_comb begin
		logic [63:0] k;
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		k = {cfg_wdata[62:0], 1'b0} & 64'hFEFE_FEFE_FEFE_FEFE;
		cd = des_pkg::pc1_perm(k);
		c = cd[55:28];
		d = cd[27:0];
		for (int i = 0; i < ROUNDS; i++) begin
			c = des_pkg::rot28(c, des_pkg::ROT_TAB[i[3:0]]);
			d = des_pkg::rot28(d, des_pkg::ROT_TAB[i[3:0]]);
			sk_n[i] = des_pkg::pc2_perm({c, d});
		end
	end

	// Reset value of the zero key's schedule is also zero after PC-2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			for (int i = 0; i < ROUNDS; i++) sk_q[i] <= '0;
		end else if (cfg_we) begin
			key_q <= cfg_wdata;
			for (int i = 0; i < ROUNDS; i++) sk_q[i] <= sk_n[i];
		end
	end

	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lr[0] <= des_pkg::ip_perm(in_ch.data[63:0]);
			cmd[0] <= in_ch.data[64];
		end
	end

	for (genvar g = 0; g < ROUNDS; g++) begin : g_round
		logic [47:0] key_sel;
		assign key_sel = cmd[g] ? sk_q[ROUNDS-1-g] : sk_q[g];
		des_round u_round (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld[g]), .lr_in(lr[g]), .key(key_sel),
			.vld_out(vld[g+1]), .lr_out(lr[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				cmd[g+1] <= cmd[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= des_pkg::fp_perm({lr[ROUNDS][31:0], lr[ROUNDS][63:32]});
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_key: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> key_q == $past(cfg_wdata))
		else $error("key not captured");
`endif
endmodule

// ===== tb/des_checker.sv =====
`timescale 1ns / 1ps
// Checker for the DES block cipher: watches the key port and both channels, predicts each result.
// Depends on des_pkg for its tables; the channels come in as plain ports.
module des_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [64:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_data,
	output int          fail_count,
	output int          pending
);
	import des_pkg::*;

	logic [47:0] subkeys [0:15];
	logic [63:0] expected_blocks [$];

	function automatic logic [31:0] round_mix(input logic [31:0] r, input logic [47:0] k);
		logic [47:0] e;
		logic [31:0] s;
		logic [31:0] o;
		logic [5:0] six;
		for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(E_TAB[i])];
		e ^= k;
		for (int b = 0; b < 8; b++) begin
			six = e[47-6*b -: 6];
			s[31-4*b -: 4] = SBOX[b][int'({six[5], six[0]}) * 16 + int'(six[4:1])];
		end
		for (int i = 0; i < 32; i++) o[31-i] = s[32-int'(P_TAB[i])];
		return o;
	endfunction

	task automatic load_key(input logic [63:0] key);
		logic [63:0] k;
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		k = (key << 1) & 64'hFEFEFEFEFEFEFEFE;
		for (int i = 0; i < 56; i++) cd[55-i] = k[64-int'(PC1_TAB[i])];
		c = cd[55:28];
		d = cd[27:0];
		for (int r = 0; r < 16; r++) begin
			repeat (int'(ROT_TAB[r])) begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end
			cd = {c, d};
			for (int i = 0; i < 48; i++) subkeys[r][47-i] = cd[56-int'(PC2_TAB[i])];
		end
	endtask

	function automatic logic [63:0] cipher_block(input logic decrypt, input logic [63:0] blk);
		logic [63:0] x;
		logic [63:0] y;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] nr;
		for (int i = 0; i < 64; i++) x[63-i] = blk[64-int'(IP_TAB[i])];
		l = x[63:32];
		r = x[31:0];
		for (int i = 0; i < 16; i++) begin
			nr = l ^ round_mix(r, subkeys[decrypt ? 15 - i : i]);
			l = r;
			r = nr;
		end
		x = {r, l};
		for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(FP_TAB[i])];
		return y;
	endfunction

	initial begin
		fail_count = 0;
		load_key(64'd0);
	end

	assign pending = expected_blocks.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) load_key(cfg_wdata);
			if (in_valid && in_ready)
				expected_blocks.push_back(cipher_block(in_data[64], in_data[63:0]));
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					$display("%t: unexpected beat, actual %h", $time, out_data);
					fail_count++;
				end else begin
					if (out_data !== expected_blocks[0]) begin
						$display("%t: result_block expected %h actual %h", $time,
							expected_blocks[0], out_data);
						fail_count++;
					end
					void'(expected_blocks.pop_front());
				end
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the DES block cipher testbench: clock, reset, key writes and block stimulus.
// Depends on des_pkg, des_stream_if, des_block_cipher and des_checker.
module testbench;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	int          fail_count;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;

	des_stream_if #(.W(65)) in_ch ();
	des_stream_if #(.W(64)) out_ch ();

	des_block_cipher dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	des_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic send_block(input logic cmd, input logic [63:0] blk);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {cmd, blk};
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_key(input logic [63:0] key);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [63:0] key_list [0:5];
		logic [63:0] blk;
		int          mode;
		key_list = '{64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h133457799BBCDFF1,
			64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080, 64'h0E329232EA6D0D73};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset key, then the named key patterns.
		send_block(1'b0, 64'h0);
		send_block(1'b1, 64'h0);
		send_block(1'b0, 64'hFFFFFFFFFFFFFFFF);
		send_block(1'b1, 64'hFFFFFFFFFFFFFFFF);
		for (int k = 1; k < 6; k++) begin
			write_key(key_list[k]);
			send_block(1'b0, 64'h0123456789ABCDEF);
			send_block(1'b1, 64'h85E813540F0AB405);
			send_block(1'b0, 64'h8000000000000001);
			send_block(1'b1, 64'hFFFFFFFFFFFFFFFF);
		end

		for (int ph = 0; ph < 13; ph++) begin
			mode = ph % 4;
			idle_pct = (mode == 1) ? 80 : (mode == 3) ? 9 : 0;
			stall_pct = (mode == 2) ? 80 : (mode == 3) ? 9 : 0;
			write_key((ph % 3 == 0) ? key_list[ph % 6] : rand64());
			for (int i = 0; i < 100; i++) begin
				blk = rand64();
				if ($urandom_range(19) == 0) blk = $urandom_range(1) ? '1 : '0;
				send_block(1'($urandom_range(1)), blk);
			end
		end
		in_ch.valid <= 1'b0;
		stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule

// ===== files.f =====
sv/des_pkg.sv
sv/des_stream_if.sv
sv/des_round.sv
sv/des_block_cipher.sv
tb/des_checker.sv
tb/testbench.sv
